### hdl/octahedral_normal_encode_assert.svh
// assertion helpers for the octahedral encoder
`ifndef OCTAHEDRAL_NORMAL_ENCODE_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_ENCODE_ASSERT_SVH

// same-cycle implication, off during reset
`define ONENC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("onenc check failed");

// next-cycle implication, off during reset
`define ONENC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("onenc check failed");

`endif

### hdl/onenc_pkg.sv
package onenc_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 14;
  localparam int OUT_BITS           = 16;

endpackage

### hdl/onenc_dir_if.sv
interface onenc_dir_if #(
  parameter int COMPONENT_BITS = onenc_pkg::COMPONENT_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] dir_x;
  logic signed [COMPONENT_BITS-1:0] dir_y;
  logic signed [COMPONENT_BITS-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

### hdl/onenc_oct_if.sv
interface onenc_oct_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [onenc_pkg::OUT_BITS-1:0] oct_u;
  logic signed [onenc_pkg::OUT_BITS-1:0] oct_v;
  logic                                 zero_vector;

  modport source (output valid, output oct_u, output oct_v, output zero_vector, input ready);
  modport sink   (input valid, input oct_u, input oct_v, input zero_vector, output ready);
endinterface

### hdl/octahedral_normal_encode.sv
// octahedral normal encoder
// dir channel: one beat carries a signed direction (dir_x, dir_y, dir_z) on a
// common scale. oct channel: one beat per input beat, in order, with oct_u and
// oct_v in signed fixed point (FRACTION_BITS fraction bits, 1.0 = 1 << F) and
// zero_vector set for an all-zero input, coordinates then 0.
// pipeline: one stage forms magnitudes and the L1 sum, FRACTION_BITS + 2
// restoring divide stages produce one quotient bit each for u and v side by
// side, and a last stage rounds, folds the lower hemisphere and attaches signs.
// throughput is one beat per cycle while oct does not stall.
// a stall on oct holds the output register; upstream stages keep filling any
// empty slot, so dir.ready stays high until every stage holds a beat.
// reset (rst, synchronous) empties all stages; no state links one beat to the
// next.
`include "octahedral_normal_encode_assert.svh"

module octahedral_normal_encode #(
  parameter int COMPONENT_BITS = onenc_pkg::COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = onenc_pkg::FRACTION_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  onenc_dir_if.sink    dir,
  onenc_oct_if.source  oct
);

  localparam int CB = COMPONENT_BITS;
  localparam int SW = COMPONENT_BITS + 2;        // L1 sum width
  localparam int QW = FRACTION_BITS + 2;         // quotient bits, one per divide stage
  localparam int NS = QW + 2;                    // total stages
  localparam int OB = onenc_pkg::OUT_BITS;
  localparam int XW = QW + OB;                   // signed work width for the output

  logic [NS-1:0] vld;
  logic [NS-1:0] load;

  // per-stage payload, index 0 is the magnitude stage, 1..QW the divide stages
  logic [SW-1:0] sum   [0:QW];
  logic [SW-1:0] rem_u [0:QW];
  logic [SW-1:0] rem_v [0:QW];
  logic [QW-1:0] q_u   [0:QW];
  logic [QW-1:0] q_v   [0:QW];
  logic          neg_x [0:QW];
  logic          neg_y [0:QW];
  logic          neg_z [0:QW];
  logic          zero  [0:QW];

  logic [CB-1:0] mag_x, mag_y, mag_z;
  logic [SW-1:0] sum_in;

  logic [QW:0]        rnd_u, rnd_v;
  logic [QW-1:0]      mu, mv, fu, fv, su, sv;
  logic signed [XW-1:0] wu, wv;
  logic signed [OB-1:0] oct_u_next, oct_v_next;

  // a stage loads when it is empty or its beat moves on
  always_comb begin
    load[NS-1] = !vld[NS-1] || oct.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign dir.ready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= dir.valid;
      for (int i = 1; i < NS; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // magnitudes and L1 norm
  assign mag_x  = dir.dir_x[CB-1] ? CB'(~dir.dir_x + 1'b1) : CB'(dir.dir_x);
  assign mag_y  = dir.dir_y[CB-1] ? CB'(~dir.dir_y + 1'b1) : CB'(dir.dir_y);
  assign mag_z  = dir.dir_z[CB-1] ? CB'(~dir.dir_z + 1'b1) : CB'(dir.dir_z);
  assign sum_in = SW'(mag_x) + SW'(mag_y) + SW'(mag_z);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sum[0]   <= sum_in;
      rem_u[0] <= SW'(mag_x);
      rem_v[0] <= SW'(mag_y);
      q_u[0]   <= '0;
      q_v[0]   <= '0;
      neg_x[0] <= dir.dir_x[CB-1];
      neg_y[0] <= dir.dir_y[CB-1];
      neg_z[0] <= dir.dir_z[CB-1];
      zero[0]  <= (sum_in == '0);
    end
  end

  // restoring divide, quotient of mag * 2^(F+1) / sum, msb first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [SW:0] cu, cv;
    logic        bu, bv;

    if (k == 1) begin : g_first
      assign cu = {1'b0, rem_u[k-1]};
      assign cv = {1'b0, rem_v[k-1]};
    end else begin : g_rest
      assign cu = {rem_u[k-1], 1'b0};
      assign cv = {rem_v[k-1], 1'b0};
    end

    assign bu = (cu >= {1'b0, sum[k-1]});
    assign bv = (cv >= {1'b0, sum[k-1]});

    always_ff @(posedge clk) begin
      if (load[k]) begin
        rem_u[k] <= bu ? SW'(cu - {1'b0, sum[k-1]}) : SW'(cu);
        rem_v[k] <= bv ? SW'(cv - {1'b0, sum[k-1]}) : SW'(cv);
        q_u[k]   <= {q_u[k-1][QW-2:0], bu};
        q_v[k]   <= {q_v[k-1][QW-2:0], bv};
        sum[k]   <= sum[k-1];
        neg_x[k] <= neg_x[k-1];
        neg_y[k] <= neg_y[k-1];
        neg_z[k] <= neg_z[k-1];
        zero[k]  <= zero[k-1];
      end
    end
  end

  // round half away (magnitudes), fold for negative z, reattach signs
  assign rnd_u = {1'b0, q_u[QW]} + (QW+1)'(1);
  assign rnd_v = {1'b0, q_v[QW]} + (QW+1)'(1);
  assign mu    = rnd_u[QW:1];
  assign mv    = rnd_v[QW:1];
  assign fu    = (QW'(1) << FRACTION_BITS) - mv;
  assign fv    = (QW'(1) << FRACTION_BITS) - mu;
  assign su    = neg_z[QW] ? fu : mu;
  assign sv    = neg_z[QW] ? fv : mv;
  assign wu    = neg_x[QW] ? -$signed(XW'(su)) : $signed(XW'(su));
  assign wv    = neg_y[QW] ? -$signed(XW'(sv)) : $signed(XW'(sv));

  always_comb begin
    if (zero[QW]) begin
      oct_u_next = '0;
      oct_v_next = '0;
    end else begin
      oct_u_next = wu[OB-1:0];
      oct_v_next = wv[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[NS-1]) begin
      oct.oct_u       <= oct_u_next;
      oct.oct_v       <= oct_v_next;
      oct.zero_vector <= zero[QW];
    end
  end

  assign oct.valid = vld[NS-1];

  `ONENC_ASSERT_NOW(a_zero_out, clk, rst, oct.valid && oct.zero_vector, (oct.oct_u == '0) && (oct.oct_v == '0))
  `ONENC_ASSERT_NOW(a_full_stall, clk, rst, (&vld) && !oct.ready, !dir.ready)
  `ONENC_ASSERT_NOW(a_rem_bound, clk, rst, vld[QW] && (sum[QW] != '0), (rem_u[QW] < sum[QW]) && (rem_v[QW] < sum[QW]))

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CB        = onenc_pkg::COMPONENT_BITS_DEF;
  localparam int FB        = onenc_pkg::FRACTION_BITS_DEF;
  localparam int OB        = onenc_pkg::OUT_BITS;
  localparam int LATENCY   = FB + 3;
  localparam int HOLD_LEN  = 120;
  localparam int N_DIRECTED = 21;

  typedef struct {
    logic signed [OB-1:0] u;
    logic signed [OB-1:0] v;
    logic                 zv;
  } oct_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    bit                   typed;
    oct_t                 res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  onenc_dir_if #(.COMPONENT_BITS(CB)) dir_ch ();
  onenc_oct_if                        oct_ch ();

  octahedral_normal_encode #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS (FB)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .dir(dir_ch),
    .oct(oct_ch)
  );

  always #5 clk = ~clk;

  oct_t     pending_oct[$];
  int       mismatch_cnt  = 0;
  int       src_idle_pct  = 0;
  int       snk_stall_pct = 0;
  bit       long_hold_req = 1'b0;
  int       hold_left     = 0;
  dir_row_t directed_rows [0:N_DIRECTED-1];

  // expected octahedral coordinates of one direction
  function automatic oct_t encode_dir(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                      logic signed [CB-1:0] z);
    oct_t r;
    longint sx, sy, sz, su, sv;
    longint unsigned ax, ay, az, l1, mu, mv, fu;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    l1 = ax + ay + az;
    if (l1 == 0) begin
      r.u  = '0;
      r.v  = '0;
      r.zv = 1'b1;
      return r;
    end
    // round to nearest, ties away from zero, on the magnitude
    mu = ((ax << (FB + 1)) + l1) / (l1 << 1);
    mv = ((ay << (FB + 1)) + l1) / (l1 << 1);
    if (sz < 0) begin
      fu = (64'd1 << FB) - mv;
      mv = (64'd1 << FB) - mu;
      mu = fu;
    end
    su = (sx < 0) ? -longint'(mu) : longint'(mu);
    sv = (sy < 0) ? -longint'(mv) : longint'(mv);
    r.u  = su[OB-1:0];
    r.v  = sv[OB-1:0];
    r.zv = 1'b0;
    return r;
  endfunction

  // drive one beat, wait for acceptance, then queue its expectation
  task automatic send_dir(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                          logic signed [CB-1:0] z, bit typed, oct_t typed_res);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      dir_ch.valid <= 1'b0;
      @(posedge clk);
    end
    dir_ch.valid <= 1'b1;
    dir_ch.dir_x <= x;
    dir_ch.dir_y <= y;
    dir_ch.dir_z <= z;
    do @(posedge clk); while (!dir_ch.ready);
    if (typed) pending_oct.push_back(typed_res);
    else pending_oct.push_back(encode_dir(x, y, z));
  endtask

  function automatic logic signed [CB-1:0] pick_comp(int mode);
    logic signed [CB-1:0] c;
    case (mode)
      0: c = CB'($urandom);
      1: c = CB'($urandom_range(0, 30)) - CB'(15);
      2: c = '0;
      default: begin
        case ($urandom_range(0, 4))
          0: c = {1'b1, {(CB-1){1'b0}}};
          1: c = {1'b0, {(CB-1){1'b1}}};
          2: c = '1;
          3: c = CB'(1);
          default: c = '0;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic send_random(int n);
    logic signed [CB-1:0] x, y, z;
    oct_t none;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          x = pick_comp(0);
          y = pick_comp(0);
          z = pick_comp(0);
        end
        4: begin
          x = pick_comp(1);
          y = pick_comp(1);
          z = pick_comp(1);
        end
        5: begin
          // tiny x and y against a large negative z
          x = pick_comp(1);
          y = pick_comp(1);
          z = -CB'($urandom_range(1000, 32768));
        end
        6: begin
          x = pick_comp($urandom_range(0, 3));
          y = pick_comp($urandom_range(0, 3));
          z = pick_comp($urandom_range(0, 3));
        end
        7: begin
          x = pick_comp(3);
          y = pick_comp(3);
          z = pick_comp(3);
        end
        default: begin
          x = pick_comp(0);
          y = pick_comp(0);
          z = pick_comp(2);
        end
      endcase
      send_dir(x, y, z, 1'b0, none);
    end
  endtask

  task automatic drain();
    while (pending_oct.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      oct_ch.ready <= 1'b0;
      hold_left    = 0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = HOLD_LEN;
      oct_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      oct_ch.ready <= 1'b0;
    end else begin
      oct_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    oct_t want;
    if (!rst && oct_ch.valid && oct_ch.ready) begin
      if (pending_oct.size() == 0) begin
        $error("unexpected oct beat: oct_u %0d oct_v %0d zero_vector %0d",
               oct_ch.oct_u, oct_ch.oct_v, oct_ch.zero_vector);
        mismatch_cnt++;
      end else begin
        want = pending_oct.pop_front();
        if (oct_ch.oct_u !== want.u) begin
          $error("oct_u: expected %0d, actual %0d", want.u, oct_ch.oct_u);
          mismatch_cnt++;
        end
        if (oct_ch.oct_v !== want.v) begin
          $error("oct_v: expected %0d, actual %0d", want.v, oct_ch.oct_v);
          mismatch_cnt++;
        end
        if (oct_ch.zero_vector !== want.zv) begin
          $error("zero_vector: expected %0d, actual %0d", want.zv, oct_ch.zero_vector);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    dir_ch.valid <= 1'b0;
    dir_ch.dir_x <= '0;
    dir_ch.dir_y <= '0;
    dir_ch.dir_z <= '0;

    directed_rows = '{
      // all-zero input
      '{ 16'sd0,      16'sd0,      16'sd0,      1'b1, '{16'sd0,      16'sd0,      1'b1}},
      '{ 16'sd32767,  16'sd0,      16'sd0,      1'b1, '{16'sd16384,  16'sd0,      1'b0}},
      '{-16'sd32768,  16'sd0,      16'sd0,      1'b1, '{-16'sd16384, 16'sd0,      1'b0}},
      '{ 16'sd0,      16'sd32767,  16'sd0,      1'b1, '{16'sd0,      16'sd16384,  1'b0}},
      '{ 16'sd0,     -16'sd32768,  16'sd0,      1'b1, '{16'sd0,      -16'sd16384, 1'b0}},
      '{ 16'sd0,      16'sd0,      16'sd32767,  1'b1, '{16'sd0,      16'sd0,      1'b0}},
      // pure negative z folds to the corner
      '{ 16'sd0,      16'sd0,     -16'sd32768,  1'b1, '{16'sd16384,  16'sd16384,  1'b0}},
      '{ 16'sd0,      16'sd0,     -16'sd1,      1'b1, '{16'sd16384,  16'sd16384,  1'b0}},
      '{ 16'sd0,      16'sd0,      16'sd1,      1'b1, '{16'sd0,      16'sd0,      1'b0}},
      // negative component that projects to zero keeps its sign in the fold
      '{-16'sd1,      16'sd0,     -16'sd32768,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{ 16'sd0,     -16'sd1,     -16'sd32768,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{-16'sd1,     -16'sd1,     -16'sd32767,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
      // exact half, rounds away from zero
      '{ 16'sd1,      16'sd32767,  16'sd0,      1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{-16'sd1,      16'sd32767,  16'sd0,      1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{ 16'sd1,      16'sd1,      16'sd0,      1'b0, '{16'sd0, 16'sd0, 1'b0}},
      // zero z does not fold
      '{-16'sd5,      16'sd3,      16'sd0,      1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{ 16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{-16'sd32768, -16'sd32768, -16'sd32768,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{-16'sd32768,  16'sd32767, -16'sd32768,  1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{ 16'sd12345, -16'sd23456, -16'sd321,    1'b0, '{16'sd0, 16'sd0, 1'b0}},
      '{-16'sd1,      16'sd1,      16'sd1,      1'b0, '{16'sd0, 16'sd0, 1'b0}}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    foreach (directed_rows[i])
      send_dir(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
               directed_rows[i].typed, directed_rows[i].res);

    send_random(400);

    // long receiver hold-off while beats keep coming, pipe fills and stalls dir
    long_hold_req = 1'b1;
    send_random(60);

    // sender waits for the pipe to empty
    dir_ch.valid <= 1'b0;
    drain();
    @(posedge clk);

    src_idle_pct  = 67;
    snk_stall_pct = 0;
    send_random(400);

    src_idle_pct  = 0;
    snk_stall_pct = 67;
    send_random(400);

    src_idle_pct  = 22;
    snk_stall_pct = 22;
    send_random(380);

    dir_ch.valid <= 1'b0;
    drain();
    repeat (LATENCY + 8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
